@@ src/pcr_pkg.sv @@
package pcr_pkg;

  // Configuration register indexes
  localparam logic CFG_RESTITUTION = 1'b0;
  localparam logic CFG_STEP_TIME   = 1'b1;

  localparam logic [16:0] RESTITUTION_RST = 17'd32768;
  localparam logic [30:0] STEP_TIME_RST   = 31'd1092;

  // Quotient bits produced by the divider, one per stage
  localparam int DIV_STEPS = 31;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  // Quantities carried alongside the front of the pipeline
  typedef struct packed {
    logic [2:0][17:0] nrm;
    logic [30:0]      ima;
    logic [30:0]      imb;
    logic [31:0]      tim;
    logic [31:0]      pen;
  } early_t;

  // Quantities carried past the divider
  typedef struct packed {
    logic [2:0][17:0] nrm;
    logic [30:0]      ima;
    logic [30:0]      imb;
    logic             vel_ok;
    logic             pos_ok;
  } side_t;

  // Clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SAT_HI) begin
      return 32'sh7FFFFFFF;
    end else if (x < SAT_LO) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

@@ src/pcr_if.sv @@
interface pcr_in_if;
  import pcr_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] rel_vel_x;
  logic signed [31:0] rel_vel_y;
  logic signed [31:0] rel_vel_z;
  logic signed [31:0] rel_acc_x;
  logic signed [31:0] rel_acc_y;
  logic signed [31:0] rel_acc_z;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic [30:0]        inv_mass_a;
  logic [30:0]        inv_mass_b;
  logic signed [31:0] penetration;

  modport source(output valid, rel_vel_x, rel_vel_y, rel_vel_z, rel_acc_x, rel_acc_y,
                 rel_acc_z, normal_x, normal_y, normal_z, inv_mass_a, inv_mass_b,
                 penetration, input ready);
  modport sink(input valid, rel_vel_x, rel_vel_y, rel_vel_z, rel_acc_x, rel_acc_y,
               rel_acc_z, normal_x, normal_y, normal_z, inv_mass_a, inv_mass_b,
               penetration, output ready);
endinterface

interface pcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dvel_a_x;
  logic signed [31:0] dvel_a_y;
  logic signed [31:0] dvel_a_z;
  logic signed [31:0] dvel_b_x;
  logic signed [31:0] dvel_b_y;
  logic signed [31:0] dvel_b_z;
  logic signed [31:0] dpos_a_x;
  logic signed [31:0] dpos_a_y;
  logic signed [31:0] dpos_a_z;
  logic signed [31:0] dpos_b_x;
  logic signed [31:0] dpos_b_y;
  logic signed [31:0] dpos_b_z;

  modport source(output valid, dvel_a_x, dvel_a_y, dvel_a_z, dvel_b_x, dvel_b_y, dvel_b_z,
                 dpos_a_x, dpos_a_y, dpos_a_z, dpos_b_x, dpos_b_y, dpos_b_z,
                 input ready);
  modport sink(input valid, dvel_a_x, dvel_a_y, dvel_a_z, dvel_b_x, dvel_b_y, dvel_b_z,
               dpos_a_x, dpos_a_y, dpos_a_z, dpos_b_x, dpos_b_y, dpos_b_z,
               output ready);
endinterface

@@ src/particle_contact_resolver.sv @@
// Particle contact resolver, Q16.16. Takes one contact per clock unless the
// output register is held and returns velocity and position deltas for both
// particles: seven stages of dot products, restitution and acceleration
// correction, a 31-stage divider (one quotient bit per stage, both divisions
// side by side), three stages of scaling and an output register. When it is
// held the whole pipeline freezes, so ready falls only while a result waits
// and out_ch.ready is low. The user writes restitution and step time through
// the cfg_ port only while no contact is in flight; the block does not enforce it.
module particle_contact_resolver (
  input  logic        clk,
  input  logic        rst_n,
  pcr_in_if.sink      in_ch,
  pcr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [30:0] cfg_data
);
  import pcr_pkg::*;

  logic [16:0] restitution_r;
  logic [30:0] step_time_r;
  logic        adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= RESTITUTION_RST;
      step_time_r   <= STEP_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RESTITUTION: restitution_r <= cfg_data[16:0];
        CFG_STEP_TIME:   step_time_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [17:0] rest_s;
  logic signed [31:0] step_s;
  assign rest_s = $signed({1'b0, restitution_r});
  assign step_s = $signed({1'b0, step_time_r});

  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic vd_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r} <= '0;
      for (int k = 0; k < DIV_STEPS; k++) vd_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      vd_r[0] <= v7_r;
      for (int k = 1; k < DIV_STEPS; k++) vd_r[k] <= vd_r[k-1];
      v8_r <= vd_r[DIV_STEPS-1];
      v9_r <= v8_r;
      v10_r <= v9_r;
      out_valid_r <= v10_r;
    end
  end

  // Stage 1: component products and total inverse mass
  logic signed [31:0] vel[3], acc[3];
  logic signed [17:0] nin[3];
  logic signed [49:0] s1_pv_r[3], s1_pa_r[3];
  early_t             s1_e_r;

  assign vel[0] = in_ch.rel_vel_x;
  assign vel[1] = in_ch.rel_vel_y;
  assign vel[2] = in_ch.rel_vel_z;
  assign acc[0] = in_ch.rel_acc_x;
  assign acc[1] = in_ch.rel_acc_y;
  assign acc[2] = in_ch.rel_acc_z;
  assign nin[0] = in_ch.normal_x;
  assign nin[1] = in_ch.normal_y;
  assign nin[2] = in_ch.normal_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_pv_r[i]     <= 50'(vel[i]) * 50'(nin[i]);
        s1_pa_r[i]     <= 50'(acc[i]) * 50'(nin[i]);
        s1_e_r.nrm[i]  <= nin[i];
      end
      s1_e_r.ima <= in_ch.inv_mass_a;
      s1_e_r.imb <= in_ch.inv_mass_b;
      s1_e_r.tim <= {1'b0, in_ch.inv_mass_a} + {1'b0, in_ch.inv_mass_b};
      s1_e_r.pen <= in_ch.penetration;
    end
  end

  // Stage 2: dot products, separating velocity and acceleration along normal
  logic signed [51:0] dotv, dota;
  logic signed [31:0] s2_sv_r, s2_ad_r;
  early_t             s2_e_r;

  assign dotv = 52'(s1_pv_r[0]) + 52'(s1_pv_r[1]) + 52'(s1_pv_r[2]);
  assign dota = 52'(s1_pa_r[0]) + 52'(s1_pa_r[1]) + 52'(s1_pa_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sv_r <= sat32(64'($signed(dotv[51:16])));
      s2_ad_r <= sat32(64'($signed(dota[51:16])));
      s2_e_r  <= s1_e_r;
    end
  end

  // Stage 3: restitution and step time products
  logic signed [32:0] neg_sv;
  logic signed [50:0] s3_pn_r;
  logic signed [63:0] s3_pt_r;
  logic signed [31:0] s3_sv_r;
  logic               s3_cl_r;
  early_t             s3_e_r;

  assign neg_sv = -33'(s2_sv_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pn_r <= 51'(neg_sv) * 51'(rest_s);
      s3_pt_r <= 64'(s2_ad_r) * 64'(step_s);
      s3_sv_r <= s2_sv_r;
      s3_cl_r <= s2_sv_r[31];
      s3_e_r  <= s2_e_r;
    end
  end

  // Stage 4: scale back the target and acceleration-caused velocities
  logic signed [31:0] s4_nsv_r, s4_asv_r, s4_sv_r;
  logic               s4_cl_r;
  early_t             s4_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nsv_r <= sat32(64'($signed(s3_pn_r[50:16])));
      s4_asv_r <= sat32(64'($signed(s3_pt_r[63:16])));
      s4_sv_r  <= s3_sv_r;
      s4_cl_r  <= s3_cl_r;
      s4_e_r   <= s3_e_r;
    end
  end

  // Stage 5: restitution times acceleration-caused velocity
  logic signed [49:0] s5_term_r;
  logic signed [31:0] s5_nsv_r, s5_sv_r;
  logic               s5_an_r, s5_cl_r;
  early_t             s5_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_term_r <= 50'(s4_asv_r) * 50'(rest_s);
      s5_nsv_r  <= s4_nsv_r;
      s5_an_r   <= s4_asv_r[31];
      s5_sv_r   <= s4_sv_r;
      s5_cl_r   <= s4_cl_r;
      s5_e_r    <= s4_e_r;
    end
  end

  // Stage 6: remove acceleration-caused closing velocity from the target, clamped at zero
  logic signed [35:0] nsv_sum;
  logic signed [31:0] nsv_fix;
  logic signed [31:0] s6_nsv_r, s6_sv_r;
  logic               s6_cl_r;
  early_t             s6_e_r;

  assign nsv_sum = 36'(s5_nsv_r) + 36'($signed(s5_term_r[49:16]));

  always_comb begin
    if (!s5_an_r) begin
      nsv_fix = s5_nsv_r;
    end else if (nsv_sum < 0) begin
      nsv_fix = '0;
    end else begin
      nsv_fix = sat32(64'(nsv_sum));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_nsv_r <= nsv_fix;
      s6_sv_r  <= s5_sv_r;
      s6_cl_r  <= s5_cl_r;
      s6_e_r   <= s5_e_r;
    end
  end

  // Stage 7: velocity change and divider operands
  logic signed [35:0] dv_diff;
  logic signed [31:0] dv;
  logic [30:0]        s7_dnum_r, s7_pnum_r;
  logic [31:0]        s7_tim_r;
  side_t              s7_side_r;
  logic               tim_nz, pen_pos;

  assign dv_diff = 36'(s6_nsv_r) - 36'(s6_sv_r);
  assign dv      = sat32(64'(dv_diff));
  assign tim_nz  = (s6_e_r.tim != '0);
  assign pen_pos = !s6_e_r.pen[31] && (s6_e_r.pen != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_dnum_r        <= s6_cl_r ? dv[30:0] : '0;
      s7_pnum_r        <= pen_pos ? s6_e_r.pen[30:0] : '0;
      s7_tim_r         <= s6_e_r.tim;
      s7_side_r.nrm    <= s6_e_r.nrm;
      s7_side_r.ima    <= s6_e_r.ima;
      s7_side_r.imb    <= s6_e_r.imb;
      s7_side_r.vel_ok <= s6_cl_r && tim_nz;
      s7_side_r.pos_ok <= pen_pos && tim_nz;
    end
  end

  // Impulse and movement per unit inverse mass
  logic [30:0] q_imp, q_mov;
  logic        sat_imp, sat_mov;

  pcr_div u_div (
    .clk   (clk),
    .en    (adv),
    .num_a (s7_dnum_r),
    .num_b (s7_pnum_r),
    .den   (s7_tim_r),
    .q_a   (q_imp),
    .q_b   (q_mov),
    .sat_a (sat_imp),
    .sat_b (sat_mov)
  );

  side_t side_dly_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly_r[0] <= s7_side_r;
      for (int k = 1; k < DIV_STEPS; k++) side_dly_r[k] <= side_dly_r[k-1];
    end
  end

  side_t              sd;
  logic signed [31:0] ipm, mpi;
  assign sd  = side_dly_r[DIV_STEPS-1];
  assign ipm = sat_imp ? 32'sh7FFFFFFF : $signed({1'b0, q_imp});
  assign mpi = sat_mov ? 32'sh7FFFFFFF : $signed({1'b0, q_mov});

  // Stage 8: spread along the normal
  logic signed [49:0] s8_pi_r[3], s8_pm_r[3];
  side_t              s8_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_pi_r[i] <= 50'($signed(sd.nrm[i])) * 50'(ipm);
        s8_pm_r[i] <= 50'($signed(sd.nrm[i])) * 50'(mpi);
      end
      s8_side_r <= sd;
    end
  end

  // Stage 9: impulse and movement components
  logic signed [31:0] s9_imp_r[3], s9_mv_r[3];
  side_t              s9_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s9_imp_r[i] <= sat32(64'($signed(s8_pi_r[i][49:16])));
        s9_mv_r[i]  <= sat32(64'($signed(s8_pm_r[i][49:16])));
      end
      s9_side_r <= s8_side_r;
    end
  end

  // Stage 10: scale by each particle's inverse mass
  logic signed [31:0] ima_s, imb_s;
  logic signed [63:0] s10_va_r[3], s10_vb_r[3], s10_pa_r[3], s10_pb_r[3];
  logic               s10_vok_r, s10_pok_r;

  assign ima_s = $signed({1'b0, s9_side_r.ima});
  assign imb_s = $signed({1'b0, s9_side_r.imb});

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s10_va_r[i] <= 64'(s9_imp_r[i]) * 64'(ima_s);
        s10_vb_r[i] <= 64'(s9_imp_r[i]) * 64'(imb_s);
        s10_pa_r[i] <= 64'(s9_mv_r[i]) * 64'(ima_s);
        s10_pb_r[i] <= 64'(s9_mv_r[i]) * 64'(imb_s);
      end
      s10_vok_r <= s9_side_r.vel_ok;
      s10_pok_r <= s9_side_r.pos_ok;
    end
  end

  // Output register: B moves opposite to A, floor taken after negation
  logic signed [63:0] nvb[3], npb[3];
  logic signed [31:0] dva_r[3], dvb_r[3], dpa_r[3], dpb_r[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvb[i] = -s10_vb_r[i];
      npb[i] = -s10_pb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dva_r[i] <= s10_vok_r ? sat32(64'($signed(s10_va_r[i][63:16]))) : '0;
        dvb_r[i] <= s10_vok_r ? sat32(64'($signed(nvb[i][63:16]))) : '0;
        dpa_r[i] <= s10_pok_r ? sat32(64'($signed(s10_pa_r[i][63:16]))) : '0;
        dpb_r[i] <= s10_pok_r ? sat32(64'($signed(npb[i][63:16]))) : '0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.dvel_a_x = dva_r[0];
  assign out_ch.dvel_a_y = dva_r[1];
  assign out_ch.dvel_a_z = dva_r[2];
  assign out_ch.dvel_b_x = dvb_r[0];
  assign out_ch.dvel_b_y = dvb_r[1];
  assign out_ch.dvel_b_z = dvb_r[2];
  assign out_ch.dpos_a_x = dpa_r[0];
  assign out_ch.dpos_a_y = dpa_r[1];
  assign out_ch.dpos_a_z = dpa_r[2];
  assign out_ch.dpos_b_x = dpb_r[0];
  assign out_ch.dpos_b_y = dpb_r[1];
  assign out_ch.dpos_b_z = dpb_r[2];

endmodule

@@ src/pcr_div.sv @@
// Two-lane pipelined restoring divider: q = floor(num * 2^16 / den),
// one quotient bit per stage, with a flag for quotients beyond 31 bits.
module pcr_div (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] num_a,
  input  logic [30:0] num_b,
  input  logic [31:0] den,
  output logic [30:0] q_a,
  output logic [30:0] q_b,
  output logic        sat_a,
  output logic        sat_b
);
  import pcr_pkg::*;

  logic [31:0] den_r   [DIV_STEPS];
  logic [31:0] rem_a_r [DIV_STEPS];
  logic [31:0] rem_b_r [DIV_STEPS];
  logic [30:0] bits_a_r[DIV_STEPS];
  logic [30:0] bits_b_r[DIV_STEPS];
  logic [30:0] quo_a_r [DIV_STEPS];
  logic [30:0] quo_b_r [DIV_STEPS];
  logic        sat_a_r [DIV_STEPS];
  logic        sat_b_r [DIV_STEPS];

  // One restoring step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] r;
    logic        ge;
    t  = {rem, nb};
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {ge, r[31:0]};
  endfunction

  logic [32:0] st0_a, st0_b;
  logic [31:0] rem0_a, rem0_b;
  logic [30:0] bits0_a, bits0_b;

  // The dividend top 16 bits are below den whenever the quotient fits
  assign rem0_a  = {17'd0, num_a[30:16]} << 1 | {31'd0, num_a[15]};
  assign rem0_b  = {17'd0, num_b[30:16]} << 1 | {31'd0, num_b[15]};
  assign bits0_a = {num_a[14:0], 16'd0};
  assign bits0_b = {num_b[14:0], 16'd0};
  assign st0_a   = div_step(rem0_a, bits0_a[30], den);
  assign st0_b   = div_step(rem0_b, bits0_b[30], den);

  always_ff @(posedge clk) begin
    logic [32:0] sa, sb;
    if (en) begin
      den_r[0]    <= den;
      rem_a_r[0]  <= st0_a[31:0];
      rem_b_r[0]  <= st0_b[31:0];
      bits_a_r[0] <= {bits0_a[29:0], 1'b0};
      bits_b_r[0] <= {bits0_b[29:0], 1'b0};
      quo_a_r[0]  <= {30'd0, st0_a[32]};
      quo_b_r[0]  <= {30'd0, st0_b[32]};
      sat_a_r[0]  <= ({16'd0, num_a} >= {den, 15'd0});
      sat_b_r[0]  <= ({16'd0, num_b} >= {den, 15'd0});
      for (int k = 1; k < DIV_STEPS; k++) begin
        sa = div_step(rem_a_r[k-1], bits_a_r[k-1][30], den_r[k-1]);
        sb = div_step(rem_b_r[k-1], bits_b_r[k-1][30], den_r[k-1]);
        den_r[k]    <= den_r[k-1];
        rem_a_r[k]  <= sa[31:0];
        rem_b_r[k]  <= sb[31:0];
        bits_a_r[k] <= {bits_a_r[k-1][29:0], 1'b0};
        bits_b_r[k] <= {bits_b_r[k-1][29:0], 1'b0};
        quo_a_r[k]  <= {quo_a_r[k-1][29:0], sa[32]};
        quo_b_r[k]  <= {quo_b_r[k-1][29:0], sb[32]};
        sat_a_r[k]  <= sat_a_r[k-1];
        sat_b_r[k]  <= sat_b_r[k-1];
      end
    end
  end

  assign q_a   = quo_a_r[DIV_STEPS-1];
  assign q_b   = quo_b_r[DIV_STEPS-1];
  assign sat_a = sat_a_r[DIV_STEPS-1];
  assign sat_b = sat_b_r[DIV_STEPS-1];

endmodule

@@ tb/sv/pcr_checker.sv @@
// Watches both channels and the register port, predicts each contact's deltas
// and compares them with what the resolver returns.
module pcr_checker (
  input  logic        clk,
  input  logic        rst_n,
  pcr_in_if           in_ch,
  pcr_out_if          out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import pcr_pkg::*;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  typedef struct {
    longint f[12];
  } deltas_t;

  deltas_t     awaited_deltas[$];
  logic [16:0] restitution;
  logic [30:0] step_time;
  string       field_name[12] = '{"dvel_a_x", "dvel_a_y", "dvel_a_z",
                                   "dvel_b_x", "dvel_b_y", "dvel_b_z",
                                   "dpos_a_x", "dpos_a_y", "dpos_a_z",
                                   "dpos_b_x", "dpos_b_y", "dpos_b_z"};

  function automatic longint clamp32(input longint x);
    if (x > MAX32) begin
      return MAX32;
    end else if (x < MIN32) begin
      return MIN32;
    end
    return x;
  endfunction

  // Q16.16 product scale-back, floor
  function automatic longint q16(input longint x);
    return x >>> 16;
  endfunction

  // floor(num * 2^16 / den), num >= 0, den > 0
  function automatic longint frac_div(input longint num, input longint den);
    longint q;
    q = (num <<< 16) / den;
    return (q > MAX32) ? MAX32 : q;
  endfunction

  // Impulse and push-apart prediction for one contact
  function automatic deltas_t resolve_contact(input longint vel[3], input longint acc[3],
                                              input longint nrm[3], input longint ima,
                                              input longint imb, input longint pen,
                                              input longint rest, input longint dt);
    deltas_t d;
    longint  dotv, dota, sv, nsv, ad, asv, dv, tim, ipm, imp, mpi, mv;
    dotv = 0;
    dota = 0;
    foreach (d.f[i]) d.f[i] = 0;
    for (int i = 0; i < 3; i++) begin
      dotv += vel[i] * nrm[i];
      dota += acc[i] * nrm[i];
    end
    tim = ima + imb;
    sv = clamp32(q16(dotv));
    // closing contact: restitution, acceleration correction, impulse
    if (sv < 0) begin
      nsv = clamp32(q16(-sv * rest));
      ad  = clamp32(q16(dota));
      asv = clamp32(q16(ad * dt));
      if (asv < 0) begin
        nsv += q16(rest * asv);
        if (nsv < 0) nsv = 0;
        nsv = clamp32(nsv);
      end
      dv = clamp32(nsv - sv);
      if (tim > 0) begin
        ipm = frac_div(dv, tim);
        for (int i = 0; i < 3; i++) begin
          imp = clamp32(q16(nrm[i] * ipm));
          d.f[i]     = clamp32(q16(imp * ima));
          d.f[3 + i] = clamp32(q16(-imp * imb));
        end
      end
    end
    // interpenetration: move apart along the normal
    if (pen > 0 && tim > 0) begin
      mpi = frac_div(pen, tim);
      for (int i = 0; i < 3; i++) begin
        mv = clamp32(q16(nrm[i] * mpi));
        d.f[6 + i] = clamp32(q16(mv * ima));
        d.f[9 + i] = clamp32(q16(-mv * imb));
      end
    end
    return d;
  endfunction

  assign pending = awaited_deltas.size();

  always @(posedge clk) begin
    longint  vel[3], acc[3], nrm[3];
    longint  got[12];
    deltas_t exp_d;
    if (!rst_n) begin
      restitution = RESTITUTION_RST;
      step_time   = STEP_TIME_RST;
      awaited_deltas.delete();
      fail_count  = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_idx == CFG_RESTITUTION) begin
          restitution = cfg_data[16:0];
        end else begin
          step_time = cfg_data;
        end
      end
      // result transaction
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.dvel_a_x, out_ch.dvel_a_y, out_ch.dvel_a_z,
                out_ch.dvel_b_x, out_ch.dvel_b_y, out_ch.dvel_b_z,
                out_ch.dpos_a_x, out_ch.dpos_a_y, out_ch.dpos_a_z,
                out_ch.dpos_b_x, out_ch.dpos_b_y, out_ch.dpos_b_z};
        if (awaited_deltas.size() == 0) begin
          $error("result with no contact outstanding");
          fail_count++;
        end else begin
          exp_d = awaited_deltas.pop_front();
          foreach (got[i]) begin
            if (got[i] != exp_d.f[i]) begin
              $error("%s: expected %0d, got %0d", field_name[i], exp_d.f[i], got[i]);
              fail_count++;
            end
          end
        end
      end
      // contact transaction
      if (in_ch.valid && in_ch.ready) begin
        vel = '{longint'(in_ch.rel_vel_x), longint'(in_ch.rel_vel_y),
                longint'(in_ch.rel_vel_z)};
        acc = '{longint'(in_ch.rel_acc_x), longint'(in_ch.rel_acc_y),
                longint'(in_ch.rel_acc_z)};
        nrm = '{longint'(in_ch.normal_x), longint'(in_ch.normal_y),
                longint'(in_ch.normal_z)};
        awaited_deltas.push_back(resolve_contact(vel, acc, nrm,
                                 longint'({1'b0, in_ch.inv_mass_a}),
                                 longint'({1'b0, in_ch.inv_mass_b}),
                                 longint'(in_ch.penetration),
                                 longint'({1'b0, restitution}),
                                 longint'({1'b0, step_time})));
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Contact stimulus, back-pressure and verdict for the particle contact resolver.
module testbench;
  import pcr_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 290;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_RESTITUTION;
  logic [30:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  logic        no_idle = 1'b0;
  int          quiet_cycles = 0;
  int          out_stall = 0;

  pcr_in_if  in_ch();
  pcr_out_if out_ch();

  always #5 clk = ~clk;

  particle_contact_resolver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  pcr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Result-side back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else begin
      out_ch.ready = 1'b1;
      out_stall = gap_len();
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_contact(input logic [31:0] vx, vy, vz, ax, ay, az,
                              input logic [17:0] nx, ny, nz,
                              input logic [30:0] ima, imb, input logic [31:0] pen);
    in_ch.rel_vel_x = vx;   in_ch.rel_vel_y = vy;   in_ch.rel_vel_z = vz;
    in_ch.rel_acc_x = ax;   in_ch.rel_acc_y = ay;   in_ch.rel_acc_z = az;
    in_ch.normal_x  = nx;   in_ch.normal_y  = ny;   in_ch.normal_z  = nz;
    in_ch.inv_mass_a = ima; in_ch.inv_mass_b = imb; in_ch.penetration = pen;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    repeat (gap_len()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only once the pipeline has emptied
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_scalar();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    if (r < 8) return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
    return $urandom;
  endfunction

  function automatic logic [17:0] rnd_normal();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return ($urandom_range(0, 1) != 0) ? 18'sd65536 : -18'sd65536;
    if (r < 9) return 18'($urandom_range(0, 92682) - 46341);
    return 18'($urandom);
  endfunction

  function automatic logic [30:0] rnd_mass();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 8) return 31'($urandom_range(1, 32'h0004_0000));
    return 31'($urandom);
  endfunction

  task automatic random_contacts(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_contact(rnd_scalar(), rnd_scalar(), rnd_scalar(),
                   rnd_scalar(), rnd_scalar(), rnd_scalar(),
                   rnd_normal(), rnd_normal(), rnd_normal(),
                   rnd_mass(), rnd_mass(), rnd_scalar());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.rel_vel_x, in_ch.rel_vel_y, in_ch.rel_vel_z} = '0;
    {in_ch.rel_acc_x, in_ch.rel_acc_y, in_ch.rel_acc_z} = '0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z} = '0;
    {in_ch.inv_mass_a, in_ch.inv_mass_b, in_ch.penetration} = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed contacts at reset settings
    // all zero
    send_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // closing along x, B present, penetrating
    send_contact(-32'sd65536, 0, 0, 0, 0, 0, 18'sd65536, 0, 0,
                 31'd65536, 31'd65536, 32'sd4096);
    // separating contact
    send_contact(32'sd65536, 0, 0, 0, 0, 0, 18'sd65536, 0, 0,
                 31'd65536, 31'd65536, 32'sd4096);
    // resting contact, negative penetration
    send_contact(0, 32'sd100, 0, 0, 0, 0, 18'sd65536, 0, 0,
                 31'd65536, 0, -32'sd4096);
    // closing, zero total inverse mass
    send_contact(-32'sd65536, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 0, 0, 32'sd4096);
    // closing with closing acceleration, B absent
    send_contact(0, -32'sd131072, 0, 0, -32'sd655360, 0, 0, 18'sd65536, 0,
                 31'd65536, 0, 0);
    // acceleration strong enough to clamp the target at zero
    send_contact(0, 0, -32'sd65536, 0, 0, 32'h8000_0000, 0, 0, 18'sd65536,
                 31'd32768, 31'd32768, 32'sd1);
    // field extremes
    send_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 18'sd65536, 18'sd65536, 18'sd65536,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 -18'sd65536, -18'sd65536, -18'sd65536,
                 31'd1, 31'd0, 32'h7FFF_FFFF);
    send_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 18'h1FFFF, 18'h20000, 18'h3FFFF,
                 31'h7FFF_FFFF, 31'd1, 32'h8000_0000);
    // tiny inverse mass pushes the quotients into saturation
    send_contact(-32'sd1048576, 0, 0, 0, 0, 0, 18'sd65536, 0, 0,
                 31'd1, 31'd0, 32'sd1048576);
    // normal not of unit length
    send_contact(-32'sd65536, -32'sd65536, 0, 0, 0, 0, 18'sd12345, -18'sd99999,
                 18'sd3, 31'd200000, 31'd70000, 32'sd65536);
    wait_idle();

    // Restitution one, reset step
    write_reg(CFG_RESTITUTION, 31'd65536);
    write_reg(CFG_STEP_TIME, 31'd1092);
    send_contact(-32'sd65536, 0, 0, -32'sd65536, 0, 0, 18'sd65536, 0, 0,
                 31'd65536, 31'd65536, 32'sd8192);
    random_contacts(PHASE_ITEMS);
    wait_idle();

    // No bounce, zero step
    write_reg(CFG_RESTITUTION, 31'd0);
    write_reg(CFG_STEP_TIME, 31'd0);
    random_contacts(PHASE_ITEMS);
    wait_idle();

    // Both registers at their ceilings, restitution above one
    write_reg(CFG_RESTITUTION, 31'h1FFFF);
    write_reg(CFG_STEP_TIME, 31'h7FFF_FFFF);
    send_contact(-32'sd65536, 0, 0, -32'sd65536, 0, 0, 18'sd65536, 0, 0,
                 31'd65536, 31'd65536, 32'sd8192);
    random_contacts(PHASE_ITEMS);
    wait_idle();

    // Random settings
    write_reg(CFG_RESTITUTION, 31'($urandom_range(0, 65536)));
    write_reg(CFG_STEP_TIME, 31'($urandom_range(1, 32'h0002_0000)));
    random_contacts(PHASE_ITEMS);
    wait_idle();

    write_reg(CFG_RESTITUTION, 31'($urandom_range(0, 32'h1FFFF)));
    write_reg(CFG_STEP_TIME, 31'($urandom));
    random_contacts(PHASE_ITEMS);

    // Drain and verdict
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
